FILE: rtl/pm_pkg.sv
// shared types and constants for the polynomial multiplier
`timescale 1ns / 1ps

package pm_pkg;

  // default sizing of the coefficient stores and the multiplier
  localparam int MAX_COEFFS_DEF = 32;
  localparam int COEF_BITS_DEF  = 16;

  // fixed payload widths
  localparam int FUNC_W    = 2;
  localparam int POS_W     = 5;
  localparam int IN_COEF_W = 16;
  localparam int PPOS_W    = 6;
  localparam int VAL_W     = 40;
  localparam int DEG_W     = 5;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE_A = 1'b0,
    CFG_DEGREE_B = 1'b1
  } cfg_reg_t;

  // control that travels with the operands down the mac pipeline
  typedef struct packed {
    logic vld;
    logic first;
  } mac_ctrl_t;

endpackage

FILE: rtl/pm_if.sv
// valid/ready channel interfaces for command beats and product beats
`timescale 1ns / 1ps

interface pm_in_if import pm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [FUNC_W-1:0]           func;
  logic [POS_W-1:0]            position;
  logic signed [IN_COEF_W-1:0] coefficient;

  modport source (output valid, output func, output position, output coefficient,
                  input ready);
  modport sink   (input valid, input func, input position, input coefficient,
                  output ready);
endinterface

interface pm_out_if import pm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PPOS_W-1:0]       product_position;
  logic signed [VAL_W-1:0] product_value;
  logic                    last;

  modport source (output valid, output product_position, output product_value,
                  output last, input ready);
  modport sink   (input valid, input product_position, input product_value,
                  input last, output ready);
endinterface

FILE: rtl/pm_mac.sv
// shared multiply-accumulate unit: registered product, then accumulator
`timescale 1ns / 1ps

module pm_mac import pm_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mac_ctrl_t                   ctl,
  input  logic signed [COEF_BITS-1:0] op_a,
  input  logic signed [COEF_BITS-1:0] op_b,
  output logic signed [VAL_W-1:0]     acc,
  output logic                        busy
);

  localparam int PROD_W = 2 * COEF_BITS;

  mac_ctrl_t                prod_ctl_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_ctl_r <= '0;
    end else begin
      prod_ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    // sums wrap modulo the result width
    if (prod_ctl_r.vld) begin
      if (prod_ctl_r.first) begin
        acc_r <= VAL_W'(prod_r);
      end else begin
        acc_r <= acc_r + VAL_W'(prod_r);
      end
    end
  end

  assign acc  = acc_r;
  assign busy = prod_ctl_r.vld;

endmodule

FILE: rtl/polynomial_multiply_top.sv
// polynomial multiplier top level: coefficient stores, sequencer and output register
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    func, position, coefficient
//   out_ch    out  valid/ready    product_position, product_value, last
//   cfg_*     in   cfg_we only    cfg_idx, cfg_wdata (degree_a, degree_b)
//
// a compute beat runs one shared multiplier over the stores, one a[i]*b[k-i]
// term at a time; product k has n_k such terms (at most MAX_COEFFS), and each
// product drains through the mac pipeline before it is written out.
// in_ch.ready is low from the compute beat until the last product is in the
// output register; a stalled out_ch holds the sequencer before each product.
// reset clears control and degrees only; stores hold garbage until loaded.
`timescale 1ns / 1ps

module polynomial_multiply_top import pm_pkg::*; #(
  parameter int MAX_COEFFS = MAX_COEFFS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DEG_W-1:0]     cfg_wdata,
  pm_in_if.sink                in_ch,
  pm_out_if.source             out_ch
);

  localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int K_W   = IDX_W + 1;
  localparam int EXT_W = (COEF_BITS > IN_COEF_W) ? COEF_BITS : IN_COEF_W;
  localparam int MAXD  = MAX_COEFFS - 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DRAIN} state_t;

  // coefficient stores
  logic signed [COEF_BITS-1:0] store_a [MAX_COEFFS];
  logic signed [COEF_BITS-1:0] store_b [MAX_COEFFS];

  logic [DEG_W-1:0] deg_a_r, deg_b_r;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        da_r, da_nxt, db_r, db_nxt;
  logic [K_W-1:0]          total_r, total_nxt, k_r, k_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt, i_hi_r, i_hi_nxt;
  logic                    first_r, first_nxt;
  mac_ctrl_t               rd_ctl_r, rd_ctl_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PPOS_W-1:0]       out_pos_r, out_pos_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic                    out_last_r, out_last_nxt;

  logic signed [COEF_BITS-1:0] rd_a_r, rd_b_r;
  logic signed [EXT_W-1:0]     coef_ext;
  logic [K_W-1:0]              j_full;
  logic [IDX_W-1:0]            j_idx;
  logic [K_W-1:0]              k_inc;
  logic                        in_acc;
  logic                        out_free;
  logic signed [VAL_W-1:0]     mac_acc;
  logic                        mac_busy;

  function automatic logic [IDX_W-1:0] clamp_deg(input logic [DEG_W-1:0] d);
    return (32'(d) > MAXD) ? IDX_W'(MAXD) : IDX_W'(d);
  endfunction

  // first term index for product k
  function automatic logic [IDX_W-1:0] range_lo(input logic [K_W-1:0] k,
                                                input logic [IDX_W-1:0] db);
    logic [K_W-1:0] dbk;
    dbk = K_W'(db);
    return (k > dbk) ? IDX_W'(k - dbk) : '0;
  endfunction

  // last term index for product k
  function automatic logic [IDX_W-1:0] range_hi(input logic [K_W-1:0] k,
                                                input logic [IDX_W-1:0] da);
    return (k < K_W'(da)) ? IDX_W'(k) : da;
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign coef_ext = EXT_W'(in_ch.coefficient);
  assign j_full   = k_r - K_W'(i_r);
  assign j_idx    = j_full[IDX_W-1:0];
  assign k_inc    = k_r + K_W'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_a_r <= '0;
      deg_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEGREE_A: deg_a_r <= cfg_wdata;
        CFG_DEGREE_B: deg_b_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (in_acc && (32'(in_ch.position) < MAX_COEFFS)) begin
      if (in_ch.func == FUNC_LOAD_A) begin
        store_a[IDX_W'(in_ch.position)] <= COEF_BITS'(coef_ext);
      end
      if (in_ch.func == FUNC_LOAD_B) begin
        store_b[IDX_W'(in_ch.position)] <= COEF_BITS'(coef_ext);
      end
    end
  end

  // store reads, one term per cycle while the sequencer is in ST_MAC
  always_ff @(posedge clk) begin
    if (state_r == ST_MAC) begin
      rd_a_r <= store_a[i_r];
      rd_b_r <= store_b[j_idx];
    end
  end

  pm_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rd_ctl_r),
    .op_a  (rd_a_r),
    .op_b  (rd_b_r),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

  always_comb begin
    state_nxt     = state_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    total_nxt     = total_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    i_hi_nxt      = i_hi_r;
    first_nxt     = first_r;
    rd_ctl_nxt    = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.func == FUNC_COMPUTE)) begin
          da_nxt    = clamp_deg(deg_a_r);
          db_nxt    = clamp_deg(deg_b_r);
          total_nxt = K_W'(clamp_deg(deg_a_r)) + K_W'(clamp_deg(deg_b_r));
          k_nxt     = '0;
          i_nxt     = '0;
          i_hi_nxt  = '0;
          first_nxt = 1'b1;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        rd_ctl_nxt.vld   = 1'b1;
        rd_ctl_nxt.first = first_r;
        first_nxt        = 1'b0;
        if (i_r == i_hi_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the pipeline to empty and the output slot to open
        if (!rd_ctl_r.vld && !mac_busy && out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = PPOS_W'(k_r);
          out_val_nxt   = mac_acc;
          out_last_nxt  = (k_r == total_r);
          if (k_r == total_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_inc;
            i_nxt     = range_lo(k_inc, db_r);
            i_hi_nxt  = range_hi(k_inc, da_r);
            first_nxt = 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ctl_r    <= rd_ctl_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    total_r    <= total_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    i_hi_r     <= i_hi_nxt;
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready             = (state_r == ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.product_position = out_pos_r;
  assign out_ch.product_value    = out_val_r;
  assign out_ch.last             = out_last_r;

`ifndef ASSERT_OFF
  // term index never runs past the end of the current range
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (i_r <= i_hi_r))
    else $error("term index past range end");

  // operands enter the mac only from a term issue cycle
  a_issue_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ctl_r.vld |-> $past(state_r == ST_MAC))
    else $error("mac operands without issue");

  // a product that is not the last one means the run is still going
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (state_r != ST_IDLE))
    else $error("run ended before last product");
`endif

endmodule
